@@ rtl/fpscam_pkg.sv @@
// Shared types, constants and tables for the first-person camera view-matrix block.
// Used by fpscam_ctrl, fpscam_dp and the top level; depends on nothing else.
package fpscam_pkg;

    localparam int ANGLE_BITS_DEF  = 16;
    localparam int VECTOR_BITS_DEF = 16;

    localparam int    CORDIC_STEPS        = 28;
    localparam longint CORDIC_GAIN_Q30    = 652032874;
    localparam longint MARGIN_PER_TURN_Q32 = 6835653;

    // Item kinds.
    localparam logic [1:0] KIND_FWD    = 2'd0;
    localparam logic [1:0] KIND_RIGHT  = 2'd1;
    localparam logic [1:0] KIND_ROTATE = 2'd2;

    // Configuration register indexes.
    localparam logic [0:0] CFG_SPEED = 1'b0;
    localparam logic [0:0] CFG_SENS  = 1'b1;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_SCALE,
        OP_MAKE_T,
        OP_MUL_LO,
        OP_MUL_HI,
        OP_POS_ADD,
        OP_ROT_MUL,
        OP_ROT_YAW,
        OP_ROT_PITCH,
        OP_CO_INIT,
        OP_CO_STEP,
        OP_CO_DONE,
        OP_VMUL,
        OP_BASIS_WR,
        OP_DOT_MUL
    } dp_op_t;

    // Sequencer states; the dot-product accumulate and write-back are flags in dp_cmd_t, not ops.
    typedef enum logic [4:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_SCALE,
        ST_MAKE_T,
        ST_MV_LO,
        ST_MV_HI,
        ST_MV_ADD,
        ST_ROT_MUL,
        ST_ROT_YAW,
        ST_ROT_PITCH,
        ST_CO_INIT,
        ST_CO_STEP,
        ST_CO_DONE,
        ST_VM_MUL,
        ST_VM_WR,
        ST_DOT_MUL,
        ST_DOT_ACC,
        ST_DOT_WR,
        ST_EMIT
    } ctl_state_t;

    typedef struct packed {
        dp_op_t     op;
        logic       acc;     // accumulate the last product into the dot sum
        logic       dot_wr;  // write back the finished dot product
        logic [4:0] idx;
    } dp_cmd_t;

    typedef struct packed {
        logic [1:0] kind;
    } dp_status_t;

    // CORDIC arctangent table in 32-bit turn units.
    function automatic logic signed [31:0] atan_turn(input logic [4:0] i);
        logic signed [31:0] r;
        r = '0;
        unique case (i)
            5'd0:  r = 32'sd536870912;
            5'd1:  r = 32'sd316933406;
            5'd2:  r = 32'sd167458907;
            5'd3:  r = 32'sd85004756;
            5'd4:  r = 32'sd42667331;
            5'd5:  r = 32'sd21354465;
            5'd6:  r = 32'sd10679838;
            5'd7:  r = 32'sd5340245;
            5'd8:  r = 32'sd2670163;
            5'd9:  r = 32'sd1335087;
            5'd10: r = 32'sd667544;
            5'd11: r = 32'sd333772;
            5'd12: r = 32'sd166886;
            5'd13: r = 32'sd83443;
            5'd14: r = 32'sd41722;
            5'd15: r = 32'sd20861;
            5'd16: r = 32'sd10430;
            5'd17: r = 32'sd5215;
            5'd18: r = 32'sd2608;
            5'd19: r = 32'sd1304;
            5'd20: r = 32'sd652;
            5'd21: r = 32'sd326;
            5'd22: r = 32'sd163;
            5'd23: r = 32'sd81;
            5'd24: r = 32'sd41;
            5'd25: r = 32'sd20;
            5'd26: r = 32'sd10;
            5'd27: r = 32'sd5;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

@@ rtl/fpscam_ctrl.sv @@
// Camera-block sequencer: each item runs a move, or a rotation and basis rebuild
// (other kinds: neither), then dot products and column output. Depends on fpscam_pkg.
module fpscam_ctrl import fpscam_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [1:0] m_column_index,
    output logic       m_last_column,
    output dp_cmd_t    cmd,
    input  dp_status_t status
);

    ctl_state_t state_reg, state_next;
    logic [4:0] cnt_reg, cnt_next;
    logic [1:0] sel_reg, sel_next;
    logic       item_reg, item_next;

    // After reset the basis is built from the reset angles before the first item.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CO_INIT;
            cnt_reg   <= '0;
            sel_reg   <= '0;
            item_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            sel_reg   <= sel_next;
            item_reg  <= item_next;
        end
    end

    always_comb begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        sel_next       = sel_reg;
        item_next      = item_reg;
        cmd            = '{op: OP_NONE, acc: 1'b0, dot_wr: 1'b0, idx: 5'd0};
        s_ready        = 1'b0;
        m_valid        = 1'b0;
        m_column_index = cnt_reg[1:0];
        m_last_column  = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.op     = OP_LOAD;
                    item_next  = 1'b1;
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                sel_next = '0;
                cnt_next = '0;
                priority case (status.kind)
                    KIND_FWD, KIND_RIGHT: state_next = ST_SCALE;
                    KIND_ROTATE:          state_next = ST_ROT_MUL;
                    default:              state_next = ST_DOT_MUL;
                endcase
            end
            ST_SCALE: begin
                cmd.op     = OP_SCALE;
                state_next = ST_MAKE_T;
            end
            ST_MAKE_T: begin
                cmd.op     = OP_MAKE_T;
                sel_next   = '0;
                state_next = ST_MV_LO;
            end
            ST_MV_LO: begin
                cmd.op     = OP_MUL_LO;
                cmd.idx    = {3'd0, sel_reg};
                state_next = ST_MV_HI;
            end
            ST_MV_HI: begin
                cmd.op     = OP_MUL_HI;
                cmd.idx    = {3'd0, sel_reg};
                state_next = ST_MV_ADD;
            end
            ST_MV_ADD: begin
                cmd.op  = OP_POS_ADD;
                cmd.idx = {3'd0, sel_reg};
                if (sel_reg == 2'd2) begin
                    sel_next   = '0;
                    cnt_next   = '0;
                    state_next = ST_DOT_MUL;
                end else begin
                    sel_next   = sel_reg + 2'd1;
                    state_next = ST_MV_LO;
                end
            end
            ST_ROT_MUL: begin
                cmd.op     = OP_ROT_MUL;
                state_next = ST_ROT_YAW;
            end
            ST_ROT_YAW: begin
                cmd.op     = OP_ROT_YAW;
                state_next = ST_ROT_PITCH;
            end
            ST_ROT_PITCH: begin
                cmd.op     = OP_ROT_PITCH;
                sel_next   = '0;
                state_next = ST_CO_INIT;
            end
            ST_CO_INIT: begin
                cmd.op     = OP_CO_INIT;
                cmd.idx    = {3'd0, sel_reg};
                cnt_next   = '0;
                state_next = ST_CO_STEP;
            end
            ST_CO_STEP: begin
                cmd.op  = OP_CO_STEP;
                cmd.idx = cnt_reg;
                if (cnt_reg == 5'(CORDIC_STEPS - 1)) begin
                    state_next = ST_CO_DONE;
                end else begin
                    cnt_next = cnt_reg + 5'd1;
                end
            end
            ST_CO_DONE: begin
                cmd.op  = OP_CO_DONE;
                cmd.idx = {3'd0, sel_reg};
                if (sel_reg == 2'd1) begin
                    sel_next   = '0;
                    state_next = ST_VM_MUL;
                end else begin
                    sel_next   = 2'd1;
                    state_next = ST_CO_INIT;
                end
            end
            ST_VM_MUL: begin
                cmd.op     = OP_VMUL;
                cmd.idx    = {3'd0, sel_reg};
                state_next = ST_VM_WR;
            end
            ST_VM_WR: begin
                cmd.op  = OP_BASIS_WR;
                cmd.idx = {3'd0, sel_reg};
                if (sel_reg == 2'd3) begin
                    sel_next   = '0;
                    cnt_next   = '0;
                    state_next = item_reg ? ST_DOT_MUL : ST_IDLE;
                end else begin
                    sel_next   = sel_reg + 2'd1;
                    state_next = ST_VM_MUL;
                end
            end
            ST_DOT_MUL: begin
                cmd.op     = OP_DOT_MUL;
                cmd.idx    = {1'b0, sel_reg, cnt_reg[1:0]};
                state_next = ST_DOT_ACC;
            end
            ST_DOT_ACC: begin
                cmd.acc = 1'b1;
                cmd.idx = {1'b0, sel_reg, cnt_reg[1:0]};
                if (cnt_reg[1:0] == 2'd2) begin
                    state_next = ST_DOT_WR;
                end else begin
                    cnt_next   = cnt_reg + 5'd1;
                    state_next = ST_DOT_MUL;
                end
            end
            ST_DOT_WR: begin
                cmd.dot_wr = 1'b1;
                cmd.idx    = {1'b0, sel_reg, 2'd0};
                cnt_next   = '0;
                if (sel_reg == 2'd2) begin
                    state_next = ST_EMIT;
                end else begin
                    sel_next   = sel_reg + 2'd1;
                    state_next = ST_DOT_MUL;
                end
            end
            ST_EMIT: begin
                m_valid       = 1'b1;
                cmd.idx       = {3'd0, cnt_reg[1:0]};
                m_last_column = (cnt_reg[1:0] == 2'd3);
                if (m_ready) begin
                    if (cnt_reg[1:0] == 2'd3) begin
                        item_next  = 1'b0;
                        cnt_next   = '0;
                        state_next = ST_IDLE;
                    end else begin
                        cnt_next = cnt_reg + 5'd1;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

@@ rtl/fpscam_dp.sv @@
// Datapath of the camera block: state registers, shared multiplier, CORDIC rotator,
// dot-product accumulator and column output mux. Depends on fpscam_pkg.
module fpscam_dp import fpscam_pkg::*; #(
    parameter int ANGLE_BITS  = ANGLE_BITS_DEF,
    parameter int VECTOR_BITS = VECTOR_BITS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  dp_cmd_t            cmd,
    output dp_status_t         status,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [0:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    input  logic [1:0]         s_kind,
    input  logic signed [31:0] s_amount_a,
    input  logic signed [31:0] s_amount_b,
    output logic signed [31:0] m_elem_x,
    output logic signed [31:0] m_elem_y,
    output logic signed [31:0] m_elem_z,
    output logic signed [31:0] m_elem_w
);

    localparam int AB  = ANGLE_BITS;
    localparam int VB  = VECTOR_BITS;
    localparam int VF  = VB - 2;
    localparam int MB  = (VB > 17) ? VB : 17;
    localparam int PW  = 32 + MB;
    localparam int XW  = PW + 21;
    localparam int CW  = 34;
    localparam int SHC = 30 - VF;
    localparam int SHL = (VF <= 16) ? 16 - VF : 0;
    localparam int SHR = (VF > 16) ? VF - 16 : 0;

    localparam longint MARGIN = ((longint'(1) << AB) * MARGIN_PER_TURN_Q32
                                 + (longint'(1) << 31)) >>> 32;
    localparam longint LIM    = (longint'(1) << (AB - 2)) - MARGIN;

    localparam logic signed [PW-1:0] P_RND8  = PW'(128);
    localparam logic signed [PW-1:0] P_LIM   = PW'(LIM);
    localparam logic signed [PW-1:0] P_NLIM  = PW'(-LIM);
    localparam logic signed [XW-1:0] X_RNDF  = XW'(longint'(1) << (VF - 1));
    localparam logic signed [XW-1:0] X_ONE   = XW'(longint'(1) << VF);
    localparam logic signed [XW-1:0] X_NONE  = XW'(-(longint'(1) << VF));
    localparam logic signed [XW-1:0] X_MAX32 = XW'(longint'(32'h7FFF_FFFF));
    localparam logic signed [XW-1:0] X_MIN32 = XW'(-(longint'(1) << 31));
    localparam logic signed [CW-1:0] C_HALF  = CW'(longint'(1) << (SHC - 1));
    localparam logic signed [CW-1:0] C_GAIN  = CW'(CORDIC_GAIN_Q30);
    localparam logic signed [31:0]   Q_RND   = (SHR > 0) ? 32'(longint'(1) << (SHR - 1))
                                                         : 32'sd0;
    localparam logic signed [31:0]   W_ONE   = 32'sd65536;

    function automatic logic signed [VB-1:0] clamp_v(input logic signed [XW-1:0] v);
        logic signed [XW-1:0] r;
        r = v;
        if (v > X_ONE) r = X_ONE;
        if (v < X_NONE) r = X_NONE;
        return VB'(r);
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [XW-1:0] v);
        logic signed [XW-1:0] r;
        r = v;
        if (v > X_MAX32) r = X_MAX32;
        if (v < X_MIN32) r = X_MIN32;
        return 32'(r);
    endfunction

    function automatic logic signed [31:0] q16(input logic signed [VB:0] v);
        logic signed [31:0] w;
        w = 32'(v);
        return ((w <<< SHL) + Q_RND) >>> SHR;
    endfunction

    logic [15:0]          speed_reg, sens_reg;
    logic [1:0]           kind_reg;
    logic signed [31:0]   amt_a_reg, amt_b_reg;
    logic signed [PW-1:0] prod_reg, aux_reg;
    logic signed [39:0]   t_reg;
    logic [AB-1:0]        yaw_reg;
    logic signed [AB-1:0] pitch_reg;
    logic signed [31:0]   pos_reg [3];
    logic signed [VB-1:0] basis_reg [9];  // front 0..2, right 3..5, up 6..8
    logic signed [VB-1:0] trig_reg [4];   // cos yaw, sin yaw, cos pitch, sin pitch
    logic signed [CW-1:0] cx_reg, cy_reg;
    logic signed [31:0]   cz_reg;
    logic [1:0]           cq_reg;
    logic signed [XW-1:0] acc_reg;
    logic signed [31:0]   dot_reg [3];

    logic [1:0]           k, didx, vec;
    logic [3:0]           bidx;
    logic signed [VB-1:0] vel;
    logic signed [31:0]   pel;
    logic signed [31:0]   mul_a;
    logic signed [MB-1:0] mul_b;
    logic signed [PW-1:0] mul_p, rnd8, psum, pclamp;
    logic signed [XW-1:0] full, pos_sum, dot_r;
    logic [31:0]          co_u;
    logic [AB-1:0]        co_ang;
    logic signed [CW-1:0] co_dx, co_dy, co_c, co_s;
    logic signed [31:0]   co_at;
    logic signed [VB-1:0] vm, co_cv, co_sv;

    assign status.kind = kind_reg;
    assign cfg_ready   = 1'b1;

    assign k    = cmd.idx[1:0];
    assign didx = cmd.idx[3:2];

    // Front or right for moves; right, up, front for the three dot products.
    always_comb begin
        if (cmd.op == OP_DOT_MUL) begin
            unique case (didx)
                2'd0:    vec = 2'd1;
                2'd1:    vec = 2'd2;
                default: vec = 2'd0;
            endcase
        end else begin
            vec = (kind_reg == KIND_RIGHT) ? 2'd1 : 2'd0;
        end
    end

    assign bidx = {2'b00, vec} * 4'd3 + {2'b00, k};
    assign vel  = basis_reg[bidx];
    assign pel  = pos_reg[k];

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (cmd.op)
            OP_SCALE: begin
                mul_a = amt_a_reg;
                mul_b = MB'($signed({1'b0, speed_reg}));
            end
            OP_ROT_MUL: begin
                mul_a = amt_a_reg;
                mul_b = MB'($signed({1'b0, sens_reg}));
            end
            OP_ROT_YAW: begin
                mul_a = amt_b_reg;
                mul_b = MB'($signed({1'b0, sens_reg}));
            end
            OP_MUL_LO: begin
                mul_a = 32'($signed({1'b0, t_reg[19:0]}));
                mul_b = MB'(vel);
            end
            OP_MUL_HI: begin
                mul_a = 32'($signed(t_reg[39:20]));
                mul_b = MB'(vel);
            end
            OP_VMUL: begin
                mul_a = 32'(trig_reg[{1'b0, cmd.idx[0]}]);
                mul_b = MB'(trig_reg[{1'b1, cmd.idx[1]}]);
            end
            OP_DOT_MUL: begin
                mul_a = pel;
                mul_b = MB'(vel);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;
    assign rnd8  = (prod_reg + P_RND8) >>> 8;

    // Pitch update with clamping just inside the quarter turn.
    always_comb begin
        psum   = PW'(pitch_reg) + rnd8;
        pclamp = psum;
        if (psum > P_LIM) pclamp = P_LIM;
        if (psum < P_NLIM) pclamp = P_NLIM;
    end

    // Position update: the 40-bit scaled delta was multiplied in two halves.
    assign full    = (XW'(prod_reg) <<< 20) + XW'(aux_reg);
    assign pos_sum = ((full + X_RNDF) >>> VF) + XW'(pel);
    assign dot_r   = (acc_reg + X_RNDF) >>> VF;
    assign vm      = clamp_v((XW'(prod_reg) + X_RNDF) >>> VF);

    // CORDIC rotator on 32-bit turn units; the quadrant is folded back at the end.
    assign co_ang = cmd.idx[0] ? $unsigned(pitch_reg) : yaw_reg;
    assign co_u   = {co_ang, {(32 - AB){1'b0}}};
    assign co_dx  = cy_reg >>> cmd.idx;
    assign co_dy  = cx_reg >>> cmd.idx;
    assign co_at  = atan_turn(cmd.idx);

    always_comb begin
        unique case (cq_reg)
            2'd0: begin co_c = cx_reg;  co_s = cy_reg;  end
            2'd1: begin co_c = -cy_reg; co_s = cx_reg;  end
            2'd2: begin co_c = -cx_reg; co_s = -cy_reg; end
            default: begin co_c = cy_reg; co_s = -cx_reg; end
        endcase
    end

    assign co_cv = clamp_v(XW'((co_c + C_HALF) >>> SHC));
    assign co_sv = clamp_v(XW'((co_s + C_HALF) >>> SHC));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            speed_reg  <= 16'd256;
            sens_reg   <= 16'd256;
            yaw_reg    <= AB'(3) <<< (AB - 2);
            pitch_reg  <= '0;
            pos_reg[0] <= '0;
            pos_reg[1] <= '0;
            pos_reg[2] <= 32'sd196608;
        end else begin
            if (cfg_valid) begin
                unique case (cfg_index)
                    CFG_SPEED: speed_reg <= cfg_data;
                    default:   sens_reg  <= cfg_data;
                endcase
            end
            if (cmd.op == OP_ROT_YAW) begin
                yaw_reg <= yaw_reg + rnd8[AB-1:0];
            end
            if (cmd.op == OP_ROT_PITCH) begin
                pitch_reg <= AB'(pclamp);
            end
            if (cmd.op == OP_POS_ADD) begin
                pos_reg[k] <= sat32(pos_sum);
            end
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= mul_p;
        if (cmd.op == OP_LOAD) begin
            kind_reg  <= s_kind;
            amt_a_reg <= s_amount_a;
            amt_b_reg <= s_amount_b;
        end
        if (cmd.op == OP_MAKE_T) begin
            t_reg <= 40'(rnd8);
        end
        if (cmd.op == OP_MUL_HI) begin
            aux_reg <= prod_reg;
        end
        if (cmd.op == OP_CO_INIT) begin
            cq_reg <= co_u[31:30];
            cz_reg <= $signed({2'b00, co_u[29:0]});
            cx_reg <= C_GAIN;
            cy_reg <= '0;
        end
        if (cmd.op == OP_CO_STEP) begin
            if (!cz_reg[31]) begin
                cx_reg <= cx_reg - co_dx;
                cy_reg <= cy_reg + co_dy;
                cz_reg <= cz_reg - co_at;
            end else begin
                cx_reg <= cx_reg + co_dx;
                cy_reg <= cy_reg - co_dy;
                cz_reg <= cz_reg + co_at;
            end
        end
        if (cmd.op == OP_CO_DONE) begin
            trig_reg[{cmd.idx[0], 1'b0}] <= co_cv;
            trig_reg[{cmd.idx[0], 1'b1}] <= co_sv;
        end
        if (cmd.op == OP_BASIS_WR) begin
            unique case (k)
                2'd0: begin
                    basis_reg[0] <= vm;
                    basis_reg[1] <= trig_reg[3];
                    basis_reg[3] <= -trig_reg[1];
                    basis_reg[4] <= '0;
                    basis_reg[5] <= trig_reg[0];
                    basis_reg[7] <= trig_reg[2];
                end
                2'd1:    basis_reg[2] <= vm;
                2'd2:    basis_reg[6] <= -vm;
                default: basis_reg[8] <= -vm;
            endcase
        end
        if (cmd.acc) begin
            acc_reg <= ((k == 2'd0) ? '0 : acc_reg) + XW'(prod_reg);
        end
        if (cmd.dot_wr) begin
            dot_reg[didx] <= sat32((didx == 2'd2) ? dot_r : -dot_r);
        end
    end

    // Column mux; the column number is held by the sequencer while a result waits.
    always_comb begin
        unique case (k)
            2'd0: begin
                m_elem_x = q16((VB+1)'(basis_reg[3]));
                m_elem_y = q16((VB+1)'(basis_reg[6]));
                m_elem_z = q16(-((VB+1)'(basis_reg[0])));
                m_elem_w = '0;
            end
            2'd1: begin
                m_elem_x = q16((VB+1)'(basis_reg[4]));
                m_elem_y = q16((VB+1)'(basis_reg[7]));
                m_elem_z = q16(-((VB+1)'(basis_reg[1])));
                m_elem_w = '0;
            end
            2'd2: begin
                m_elem_x = q16((VB+1)'(basis_reg[5]));
                m_elem_y = q16((VB+1)'(basis_reg[8]));
                m_elem_z = q16(-((VB+1)'(basis_reg[2])));
                m_elem_w = '0;
            end
            default: begin
                m_elem_x = dot_reg[0];
                m_elem_y = dot_reg[1];
                m_elem_z = dot_reg[2];
                m_elem_w = W_ONE;
            end
        endcase
    end

endmodule

@@ rtl/fps_camera_view_matrix_update_top.sv @@
// Top level of the first-person camera view-matrix block.
// Instantiates fpscam_ctrl and fpscam_dp; depends on fpscam_pkg.

// The block keeps a camera position, yaw and pitch, and answers every accepted item
// with the four columns of the look-at view matrix, one transfer per column, column 3
// flagged as last. It works on one item at a time: a rotation runs two 28-step passes
// through the single CORDIC rotator and rebuilds the basis, a move does not; the three
// dot products of column 3 share one multiplier. After reset the block builds the basis
// from the reset angles before it takes the first item; configuration writes are taken
// at any time.
module fps_camera_view_matrix_update_top import fpscam_pkg::*; #(
    parameter int ANGLE_BITS  = ANGLE_BITS_DEF,
    parameter int VECTOR_BITS = VECTOR_BITS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [0:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_kind,
    input  logic signed [31:0] s_amount_a,
    input  logic signed [31:0] s_amount_b,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [1:0]         m_column_index,
    output logic signed [31:0] m_elem_x,
    output logic signed [31:0] m_elem_y,
    output logic signed [31:0] m_elem_z,
    output logic signed [31:0] m_elem_w,
    output logic               m_last_column
);

    dp_cmd_t    cmd;
    dp_status_t status;

    fpscam_ctrl u_ctrl (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_column_index (m_column_index),
        .m_last_column  (m_last_column),
        .cmd            (cmd),
        .status         (status)
    );

    fpscam_dp #(
        .ANGLE_BITS  (ANGLE_BITS),
        .VECTOR_BITS (VECTOR_BITS)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .status     (status),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .s_kind     (s_kind),
        .s_amount_a (s_amount_a),
        .s_amount_b (s_amount_b),
        .m_elem_x   (m_elem_x),
        .m_elem_y   (m_elem_y),
        .m_elem_z   (m_elem_z),
        .m_elem_w   (m_elem_w)
    );

endmodule
